// ----- src/tlac_pkg.sv -----
`default_nettype none
package tlac_pkg;

	localparam int ID_W    = 10;
	localparam int COST_W  = 10;
	localparam int TOTAL_W = 48;
	localparam int CMD_W   = 2;

	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_ACCESS = 2'd2;

	localparam logic [ID_W-1:0] POS_LIMIT = 10'd1023;

	typedef logic [ID_W-1:0] map_word_t;

endpackage
`default_nettype wire

// ----- src/tlac_map.sv -----
`default_nettype none
module tlac_map
	import tlac_pkg::*;
#(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  wire logic      clk,
	input  wire logic      we,
	input  wire logic [AW-1:0] waddr,
	input  wire map_word_t wdata,
	input  wire logic [AW-1:0] raddr,
	output map_word_t      rdata
);

	map_word_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ----- src/tlac_div.sv -----
`default_nettype none
module tlac_div
	import tlac_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [COST_W-1:0] num,
	input  wire logic [COST_W-1:0] den,
	output logic                   done,
	output logic [COST_W-1:0]      quot
);

	localparam int CW = $clog2(COST_W + 1);

	logic            run_q;
	logic [CW-1:0]   cnt_q;
	logic [COST_W:0] rem_q;
	logic [COST_W-1:0] quo_q;
	logic [COST_W-1:0] den_q;
	logic            done_q;

	logic [COST_W:0] trial;
	logic            ge;

	assign trial = {rem_q[COST_W-1:0], quo_q[COST_W-1]};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(COST_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// one quotient bit per cycle, restoring
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (run_q) begin
			rem_q <= ge ? (trial - {1'b0, den_q}) : trial;
			quo_q <= {quo_q[COST_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule
`default_nettype wire

// ----- src/transpose_list_access_cost_core.sv -----
`default_nettype none
// Transpose-rule self-organizing list with page-cost accounting.
// Requests: start/busy command channel with cmd and item_id. A request is
// taken at a clock edge where start is high and busy is low.
//   clear  : resets the load count and running total, done in the accept cycle.
//   load   : appends item_id at the next position if in range, done in the accept cycle.
//   access : for an in-range item_id, looks up the item position, swaps the
//            item with its predecessor in the two maps if it has one, then
//            reports access_cost and total_cost on a one-cycle done strobe.
// The access time is set by the bit-serial page divider (one quotient bit per
// cycle) plus the registered position read; the swap writes overlap the division.
// page_size is written through page_size_we/page_size_wdata; the user must
// write it only while idle, which the block does not enforce. 0 acts as 1.
// Reset clears the load count, running total and control state and sets the
// page size to 1. The map memories are not cleared by reset or clear.
// The receiver cannot stall: done is high for a single cycle per result.
module transpose_list_access_cost_core
	import tlac_pkg::*;
#(
	parameter int MAX_ITEMS = 1024
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [CMD_W-1:0]   cmd,
	input  wire logic [ID_W-1:0]    item_id,
	input  wire logic               page_size_we,
	input  wire logic [COST_W-1:0]  page_size_wdata,
	output logic                    done,
	output logic [COST_W-1:0]       access_cost,
	output logic [TOTAL_W-1:0]      total_cost
);

	localparam int DEPTH = (MAX_ITEMS < 1024) ? MAX_ITEMS : 1024;
	localparam int AW    = $clog2(DEPTH);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_POS  = 3'd1;
	localparam logic [2:0] S_PREV = 3'd2;
	localparam logic [2:0] S_SW2  = 3'd3;
	localparam logic [2:0] S_WAIT = 3'd4;

	logic [2:0]          state_q;
	logic [ID_W-1:0]     load_count_q;
	logic [TOTAL_W-1:0]  total_q;
	logic [COST_W-1:0]   page_size_q;
	logic                done_q;
	logic [COST_W-1:0]   cost_q;
	map_word_t           id_q;
	map_word_t           pos_q;
	map_word_t           prev_q;
	logic                swap_q;

	logic                accept;
	logic [ID_W:0]       pos_new;
	logic                load_ok;
	logic                id_ok;

	logic                pmem_we;
	logic [AW-1:0]       pmem_waddr;
	map_word_t           pmem_wdata;
	map_word_t           pmem_rdata;
	logic                imem_we;
	logic [AW-1:0]       imem_waddr;
	map_word_t           imem_wdata;
	map_word_t           imem_rdata;
	map_word_t           pos_m1;
	map_word_t           prev_pos_m1;

	logic                div_start;
	logic [COST_W-1:0]   div_num;
	logic [COST_W-1:0]   div_den;
	logic                div_done;
	logic [COST_W-1:0]   div_quot;
	logic [COST_W-1:0]   cost;
	logic [TOTAL_W:0]    sum;
	logic                prev_ok;

	assign busy    = (state_q != S_IDLE);
	assign accept  = start && !busy;
	assign pos_new = {1'b0, load_count_q} + {{ID_W{1'b0}}, 1'b1};
	assign id_ok   = 32'(item_id) < MAX_ITEMS;
	assign load_ok = id_ok && (pos_new <= {1'b0, POS_LIMIT}) && (32'(pos_new) < MAX_ITEMS);
	assign pos_m1  = pmem_rdata - 1'b1;
	assign prev_pos_m1 = pos_q - 1'b1;
	assign prev_ok = swap_q && (32'(imem_rdata) < MAX_ITEMS);

	// map write ports: load in idle, two swap writes afterwards
	always_comb begin
		pmem_we    = 1'b0;
		pmem_waddr = item_id[AW-1:0];
		pmem_wdata = pos_new[ID_W-1:0];
		imem_we    = 1'b0;
		imem_waddr = pos_new[AW-1:0];
		imem_wdata = item_id;
		case (state_q)
			S_IDLE: begin
				pmem_we = accept && (cmd == CMD_LOAD) && load_ok;
				imem_we = pmem_we;
			end
			S_PREV: begin
				pmem_we    = prev_ok;
				pmem_waddr = id_q[AW-1:0];
				pmem_wdata = prev_pos_m1;
				imem_we    = prev_ok;
				imem_waddr = prev_pos_m1[AW-1:0];
				imem_wdata = id_q;
			end
			S_SW2: begin
				pmem_we    = swap_q;
				pmem_waddr = prev_q[AW-1:0];
				pmem_wdata = pos_q;
				imem_we    = swap_q;
				imem_waddr = pos_q[AW-1:0];
				imem_wdata = prev_q;
			end
			default: begin
			end
		endcase
	end

	tlac_map #(.DEPTH(DEPTH), .AW(AW)) u_pos_map (
		.clk   (clk),
		.we    (pmem_we),
		.waddr (pmem_waddr),
		.wdata (pmem_wdata),
		.raddr (item_id[AW-1:0]),
		.rdata (pmem_rdata)
	);

	tlac_map #(.DEPTH(DEPTH), .AW(AW)) u_item_map (
		.clk   (clk),
		.we    (imem_we),
		.waddr (imem_waddr),
		.wdata (imem_wdata),
		.raddr (pos_m1[AW-1:0]),
		.rdata (imem_rdata)
	);

	assign div_start = (state_q == S_POS);
	assign div_num   = (pmem_rdata == '0) ? '0 : pos_m1;
	assign div_den   = (page_size_q == '0) ? COST_W'(1) : page_size_q;

	tlac_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	assign cost = div_quot + 1'b1;
	assign sum  = {1'b0, total_q} + {{(TOTAL_W + 1 - COST_W){1'b0}}, cost};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			load_count_q <= '0;
			total_q      <= '0;
			page_size_q  <= COST_W'(1);
			done_q       <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (page_size_we) begin
				page_size_q <= page_size_wdata;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (cmd)
							CMD_CLEAR: begin
								load_count_q <= '0;
								total_q      <= '0;
							end
							CMD_LOAD: begin
								if (load_ok) begin
									load_count_q <= pos_new[ID_W-1:0];
								end
							end
							CMD_ACCESS: begin
								if (id_ok) begin
									state_q <= S_POS;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_POS:  state_q <= S_PREV;
				S_PREV: state_q <= S_SW2;
				S_SW2:  state_q <= S_WAIT;
				S_WAIT: begin
					if (div_done) begin
						total_q <= sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			id_q <= item_id;
		end
		if (state_q == S_POS) begin
			pos_q  <= pmem_rdata;
			swap_q <= (pmem_rdata > ID_W'(1)) && (32'(pmem_rdata) < MAX_ITEMS);
		end
		if (state_q == S_PREV) begin
			prev_q <= imem_rdata;
			swap_q <= prev_ok;
		end
		if (state_q == S_WAIT && div_done) begin
			cost_q <= cost;
		end
	end

	assign done        = done_q;
	assign access_cost = cost_q;
	assign total_cost  = total_q;

endmodule
`default_nettype wire

// ----- src/tlac_checker.sv -----
`default_nettype none
module tlac_checker
	import tlac_pkg::*;
#(
	parameter int MAX_ITEMS = 1024
) (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               start,
	input wire logic               busy,
	input wire logic [CMD_W-1:0]   cmd,
	input wire logic [ID_W-1:0]    item_id,
	input wire logic               done,
	input wire logic [COST_W-1:0]  access_cost
);

	// an in-range access request keeps the block busy
	a_access_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd == CMD_ACCESS && 32'(item_id) < MAX_ITEMS |=> busy)
		else $error("access request did not raise busy");

	// clear, load and unused commands finish at once with no result
	a_short_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd != CMD_ACCESS |=> !busy && !done)
		else $error("non-access request produced activity");

	// a result only ends a busy interval
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy) && !busy)
		else $error("result strobe outside an access");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_cost_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> access_cost != '0)
		else $error("access cost of zero");

endmodule

bind transpose_list_access_cost_core tlac_checker #(.MAX_ITEMS(MAX_ITEMS)) u_tlac_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.cmd         (cmd),
	.item_id     (item_id),
	.done        (done),
	.access_cost (access_cost)
);
`default_nettype wire
